[rtl/bce_pkg.sv]
// ----------------------------------------------------------------------------
// Battery capacity estimator package
// Shared types, widths, curve constants and segment lookup functions.
// ----------------------------------------------------------------------------
`default_nettype none

package bce_pkg;

  localparam int DISCHARGE_POINTS = 13;
  localparam int CHARGE_POINTS    = 3;

  localparam int SAMPLE_W = 8;
  localparam int MV_W     = 13;
  localparam int PCT_W    = 7;
  localparam int CURV_W   = 11;
  localparam int DC_W     = 10;
  localparam int DSR_W    = 10;
  localparam int DIV_W    = 19;
  localparam int VPROD_W  = 20;
  localparam int PROD_W   = DSR_W + DC_W;
  localparam int RECIP_W  = 20;
  localparam int ADDR_W   = 3;
  localparam int DATA_W   = 32;

  localparam logic [VPROD_W-1:0] MV_SCALE    = VPROD_W'(2650);
  localparam logic [MV_W-1:0]    MV_BASE     = MV_W'(2650);
  localparam logic [PCT_W-1:0]   PCT_FULL    = PCT_W'(100);

  // A curve value times PCT_RECIP, shifted right by RECIP_SHIFT, is that value
  // divided by 12 for every value up to full scale.
  localparam int                 RECIP_SHIFT = 13;
  localparam logic [RECIP_W-1:0] PCT_RECIP   = RECIP_W'(683);

  localparam logic [PCT_W-1:0] RST_MAX_DROP  = PCT_W'(2);
  localparam logic [MV_W-1:0]  RST_ADC_FLOOR = MV_W'(2800);
  localparam logic [MV_W-1:0]  RST_LAST_MV   = MV_W'(3930);

  localparam logic CMD_MEASURE = 1'b0;
  localparam logic CMD_SUSPEND = 1'b1;

  localparam logic REG_MAX_DROP  = 1'b0;
  localparam logic REG_ADC_FLOOR = 1'b1;

  localparam logic [MV_W-1:0] DIS_MV [DISCHARGE_POINTS] = '{
    13'd4150, 13'd4030, 13'd3930, 13'd3880, 13'd3820, 13'd3770, 13'd3720,
    13'd3690, 13'd3670, 13'd3650, 13'd3610, 13'd3570, 13'd3450
  };
  localparam logic [CURV_W-1:0] DIS_CAP [DISCHARGE_POINTS] = '{
    11'd1200, 11'd1100, 11'd1000, 11'd900, 11'd800, 11'd700, 11'd600,
    11'd500, 11'd400, 11'd300, 11'd200, 11'd100, 11'd0
  };
  localparam logic [MV_W-1:0] CHG_MV [CHARGE_POINTS] = '{
    13'd4170, 13'd3950, 13'd3450
  };
  localparam logic [CURV_W-1:0] CHG_CAP [CHARGE_POINTS] = '{
    11'd1200, 11'd600, 11'd0
  };

  typedef struct packed {
    logic                cmd;
    logic [SAMPLE_W-1:0] sample_first;
    logic [SAMPLE_W-1:0] sample_second;
    logic [SAMPLE_W-1:0] sample_third;
    logic                charging;
  } in_req_t;

  typedef struct packed {
    logic [MV_W-1:0]  voltage_mv;
    logic [PCT_W-1:0] capacity_pct;
    logic             held;
  } out_rsp_t;

  typedef struct packed {
    logic [PCT_W-1:0] max_drop_step;
    logic [MV_W-1:0]  adc_floor_mv;
  } cfg_t;

  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  dividend;
    logic [DSR_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

  typedef struct packed {
    logic              above;
    logic              below;
    logic [MV_W-1:0]   lo_mv;
    logic [CURV_W-1:0] lo_cap;
    logic [DSR_W-1:0]  dv;
    logic [DC_W-1:0]   dc;
  } seg_t;

  function automatic seg_t find_seg_dis(logic [MV_W-1:0] vol);
    seg_t s;
    logic [MV_W-1:0]   dv_w;
    logic [CURV_W-1:0] dc_w;
    s = '0;
    s.above = vol > DIS_MV[0];
    s.below = !(vol > DIS_MV[DISCHARGE_POINTS-1]);
    for (int i = DISCHARGE_POINTS - 1; i >= 1; i--) begin
      if (vol > DIS_MV[i]) begin
        dv_w     = DIS_MV[i-1] - DIS_MV[i];
        dc_w     = DIS_CAP[i-1] - DIS_CAP[i];
        s.lo_mv  = DIS_MV[i];
        s.lo_cap = DIS_CAP[i];
        s.dv     = dv_w[DSR_W-1:0];
        s.dc     = dc_w[DC_W-1:0];
      end
    end
    return s;
  endfunction

  function automatic seg_t find_seg_chg(logic [MV_W-1:0] vol);
    seg_t s;
    logic [MV_W-1:0]   dv_w;
    logic [CURV_W-1:0] dc_w;
    s = '0;
    s.above = vol > CHG_MV[0];
    s.below = !(vol > CHG_MV[CHARGE_POINTS-1]);
    for (int i = CHARGE_POINTS - 1; i >= 1; i--) begin
      if (vol > CHG_MV[i]) begin
        dv_w     = CHG_MV[i-1] - CHG_MV[i];
        dc_w     = CHG_CAP[i-1] - CHG_CAP[i];
        s.lo_mv  = CHG_MV[i];
        s.lo_cap = CHG_CAP[i];
        s.dv     = dv_w[DSR_W-1:0];
        s.dc     = dc_w[DC_W-1:0];
      end
    end
    return s;
  endfunction

endpackage

`default_nettype wire

[rtl/bce_divider.sv]
// ----------------------------------------------------------------------------
// Battery capacity estimator divider
// Restoring divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bce_divider
  import bce_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire div_req_t div_req_i,
  output div_rsp_t      div_rsp_o
);

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             done_q, done_d;
  logic [DSR_W-1:0] rem_q, rem_d;
  logic [DIV_W-1:0] quo_q, quo_d;
  logic [DSR_W-1:0] dsr_q, dsr_d;
  logic [DSR_W:0]   shifted;
  logic             busy;

  assign busy    = (cnt_q != '0);
  assign shifted = {rem_q, quo_q[DIV_W-1]};

  always_comb begin
    cnt_d  = cnt_q;
    done_d = 1'b0;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dsr_d  = dsr_q;
    if (busy) begin
      if (shifted >= {1'b0, dsr_q}) begin
        rem_d = DSR_W'(shifted - {1'b0, dsr_q});
        quo_d = {quo_q[DIV_W-2:0], 1'b1};
      end else begin
        rem_d = shifted[DSR_W-1:0];
        quo_d = {quo_q[DIV_W-2:0], 1'b0};
      end
      cnt_d  = cnt_q - CNT_W'(1);
      done_d = (cnt_q == CNT_W'(1));
    end else if (div_req_i.start) begin
      cnt_d = CNT_W'(DIV_W);
      rem_d = '0;
      quo_d = div_req_i.dividend;
      dsr_d = div_req_i.divisor;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dsr_q <= dsr_d;
  end

  assign div_rsp_o.busy     = busy;
  assign div_rsp_o.done     = done_q;
  assign div_rsp_o.quotient = quo_q;

endmodule

`default_nettype wire

[rtl/bce_regs.sv]
// ----------------------------------------------------------------------------
// Battery capacity estimator register file
// APB-style configuration registers for drop limit and ADC floor.
// ----------------------------------------------------------------------------
`default_nettype none

module bce_regs
  import bce_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready,
  output cfg_t                   cfg_o
);

  logic [PCT_W-1:0] max_drop_q;
  logic [MV_W-1:0]  adc_floor_q;
  logic             wr_en;
  logic             reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[ADDR_W-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_drop_q  <= RST_MAX_DROP;
      adc_floor_q <= RST_ADC_FLOOR;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_MAX_DROP:  max_drop_q  <= pwdata[PCT_W-1:0];
        REG_ADC_FLOOR: adc_floor_q <= pwdata[MV_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_MAX_DROP:  prdata = DATA_W'(max_drop_q);
      REG_ADC_FLOOR: prdata = DATA_W'(adc_floor_q);
      default:       prdata = '0;
    endcase
  end

  assign cfg_o.max_drop_step = max_drop_q;
  assign cfg_o.adc_floor_mv  = adc_floor_q;

endmodule

`default_nettype wire

[rtl/battery_capacity_estimator.sv]
// ----------------------------------------------------------------------------
// Battery capacity estimator
// Voltage based fuel gauge: sample pick, millivolt conversion, curve lookup
// with interpolation through a restoring divider, and drop limiting.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake                Payload
//   in       input      in_valid_i / in_stall_o  in_req_i (in_req_t)
//   out      output     out_valid_o / out_stall_i out_rsp_o (out_rsp_t)
//   cfg      input      psel, penable, pwrite    paddr, pwdata, prdata
//
// A measure request keeps the input stalled until the limit step is done,
// on the curve through one pass of the bit-serial divider as well.
// A suspend request is taken from idle and returns nothing.
// Reset restores the register defaults and clears the history; no sweep.
// A finished result waits in the output register while the next request is
// taken; the limit step stalls only if that register is still full and out_stall_i is high.
`default_nettype none

module battery_capacity_estimator
  import bce_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire in_req_t           in_req_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output out_rsp_t               out_rsp_o,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_PICK  = 3'd1;
  localparam logic [2:0] ST_VOLT  = 3'd2;
  localparam logic [2:0] ST_SEG   = 3'd3;
  localparam logic [2:0] ST_MUL   = 3'd4;
  localparam logic [2:0] ST_DIV   = 3'd5;
  localparam logic [2:0] ST_LIMIT = 3'd7;

  cfg_t     cfg;
  div_req_t div_req;
  div_rsp_t div_rsp;

  bce_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  bce_divider u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .div_req_i (div_req),
    .div_rsp_o (div_rsp)
  );

  logic [2:0]        state_q, state_d;
  logic              out_valid_q, out_valid_d;
  out_rsp_t          out_q, out_d;
  logic [MV_W-1:0]   last_mv_q, last_mv_d;
  logic [PCT_W-1:0]  last_cap_q, last_cap_d;
  logic [PCT_W-1:0]  pend_q, pend_d;
  logic              measured_q, measured_d;

  in_req_t           req_q, req_d;
  logic [SAMPLE_W-1:0] code_q, code_d;
  logic [MV_W-1:0]   vol_q, vol_d;
  logic [PCT_W-1:0]  pct_q, pct_d;
  logic [CURV_W-1:0] lo_cap_q, lo_cap_d;
  logic [DSR_W-1:0]  diff_q, diff_d;
  logic [DSR_W-1:0]  dv_q, dv_d;
  logic [DC_W-1:0]   dc_q, dc_d;

  logic                in_accept;
  logic                out_free;
  logic [SAMPLE_W-1:0] d01, d02, d12;
  logic [SAMPLE_W:0]   sum01, sum02, sum12;
  logic [SAMPLE_W-1:0] pick;
  logic [VPROD_W-1:0]  vprod;
  logic [MV_W-1:0]     vraw;
  logic [MV_W-1:0]     vdiff;
  seg_t                seg;
  logic [PROD_W-1:0]   mprod;
  logic [CURV_W:0]     cur_sum;
  logic [CURV_W-1:0]   cur;
  logic [RECIP_W-1:0]  pct_prod;
  logic [PCT_W-1:0]    pct_quot;
  logic                drop;
  logic [PCT_W-1:0]    cap_lim;
  logic [PCT_W-1:0]    cap_new;
  logic [PCT_W-1:0]    pend_new;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    d01   = (req_q.sample_second > req_q.sample_first) ?
            req_q.sample_second - req_q.sample_first :
            req_q.sample_first - req_q.sample_second;
    d02   = (req_q.sample_third > req_q.sample_first) ?
            req_q.sample_third - req_q.sample_first :
            req_q.sample_first - req_q.sample_third;
    d12   = (req_q.sample_third > req_q.sample_second) ?
            req_q.sample_third - req_q.sample_second :
            req_q.sample_second - req_q.sample_third;
    sum01 = {1'b0, req_q.sample_first} + {1'b0, req_q.sample_second};
    sum02 = {1'b0, req_q.sample_first} + {1'b0, req_q.sample_third};
    sum12 = {1'b0, req_q.sample_second} + {1'b0, req_q.sample_third};
    if (d02 < d01) begin
      pick = (d12 < d02) ? sum12[SAMPLE_W:1] : sum02[SAMPLE_W:1];
    end else begin
      pick = (d12 < d01) ? sum12[SAMPLE_W:1] : sum01[SAMPLE_W:1];
    end
  end

  assign vprod = VPROD_W'(code_q) * MV_SCALE;
  assign vraw  = MV_W'(vprod[VPROD_W-1:SAMPLE_W]) + MV_BASE;
  assign seg   = req_q.charging ? find_seg_chg(vol_q) : find_seg_dis(vol_q);
  assign vdiff = vol_q - seg.lo_mv;
  assign mprod = PROD_W'(diff_q) * PROD_W'(dc_q);

  assign cur_sum  = {1'b0, lo_cap_q} + {1'b0, div_rsp.quotient[CURV_W-1:0]};
  assign cur      = cur_sum[CURV_W-1:0];
  assign pct_prod = RECIP_W'(cur) * PCT_RECIP;
  assign pct_quot = pct_prod[RECIP_SHIFT +: PCT_W];

  always_comb begin
    drop    = (last_cap_q > pct_q) && ((last_cap_q - pct_q) > cfg.max_drop_step);
    cap_lim = last_cap_q - cfg.max_drop_step;
    if (measured_q) begin
      if (drop) begin
        cap_new  = cap_lim;
        pend_new = (pend_q != '0) ? '0 : cap_lim;
      end else begin
        cap_new  = pct_q;
        pend_new = '0;
      end
    end else if (pct_q == '0) begin
      cap_new  = PCT_W'(1);
      pend_new = PCT_W'(1);
    end else begin
      cap_new  = pct_q;
      pend_new = '0;
    end
  end

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    last_mv_d   = last_mv_q;
    last_cap_d  = last_cap_q;
    pend_d      = pend_q;
    measured_d  = measured_q;
    req_d       = req_q;
    code_d      = code_q;
    vol_d       = vol_q;
    pct_d       = pct_q;
    lo_cap_d    = lo_cap_q;
    diff_d      = diff_q;
    dv_d        = dv_q;
    dc_d        = dc_q;
    div_req     = '0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          if (in_req_i.cmd == CMD_SUSPEND) begin
            measured_d = 1'b0;
            pend_d     = '0;
          end else begin
            req_d   = in_req_i;
            state_d = ST_PICK;
          end
        end
      end
      ST_PICK: begin
        code_d  = pick;
        state_d = ST_VOLT;
      end
      ST_VOLT: begin
        if (code_q == '0 || vraw < cfg.adc_floor_mv) begin
          vol_d = last_mv_q;
        end else begin
          vol_d     = vraw;
          last_mv_d = vraw;
        end
        state_d = ST_SEG;
      end
      ST_SEG: begin
        if (seg.above) begin
          pct_d   = PCT_FULL;
          state_d = ST_LIMIT;
        end else if (seg.below) begin
          pct_d   = '0;
          state_d = ST_LIMIT;
        end else begin
          lo_cap_d = seg.lo_cap;
          diff_d   = vdiff[DSR_W-1:0];
          dv_d     = seg.dv;
          dc_d     = seg.dc;
          state_d  = ST_MUL;
        end
      end
      ST_MUL: begin
        div_req.start    = 1'b1;
        div_req.dividend = mprod[DIV_W-1:0];
        div_req.divisor  = dv_q;
        state_d          = ST_DIV;
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          pct_d   = pct_quot;
          state_d = ST_LIMIT;
        end
      end
      ST_LIMIT: begin
        if (out_free) begin
          measured_d = 1'b1;
          pend_d     = pend_new;
          if (pend_new == '0) begin
            last_cap_d = cap_new;
          end
          out_valid_d        = 1'b1;
          out_d.voltage_mv   = vol_q;
          out_d.capacity_pct = (pend_new == '0) ? cap_new : last_cap_q;
          out_d.held         = (pend_new != '0);
          state_d            = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      last_mv_q   <= RST_LAST_MV;
      last_cap_q  <= '0;
      pend_q      <= '0;
      measured_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      last_mv_q   <= last_mv_d;
      last_cap_q  <= last_cap_d;
      pend_q      <= pend_d;
      measured_q  <= measured_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q    <= out_d;
    req_q    <= req_d;
    code_q   <= code_d;
    vol_q    <= vol_d;
    pct_q    <= pct_d;
    lo_cap_q <= lo_cap_d;
    diff_q   <= diff_d;
    dv_q     <= dv_d;
    dc_q     <= dc_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  a_cap_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_rsp_o.capacity_pct <= PCT_FULL))
    else $error("Reported capacity exceeds full scale.");

  a_volt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_rsp_o.voltage_mv >= MV_BASE))
    else $error("Reported voltage is below the conversion offset.");

  a_div_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_rsp.busy)
    else $error("Divider started while busy.");

  a_limit_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LIMIT && out_free) |=> (out_valid_q && state_q == ST_IDLE))
    else $error("Finished measurement did not reach the output register.");

endmodule

`default_nettype wire
